/* design/mts_pkg.sv */
// mts_pkg: shared constants for the markov transition sampler
// field widths of the transfer ports and parameter defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

  // fixed widths of the port fields
  localparam int COMMAND_W   = 1;
  localparam int STATE_FLD_W = 4;
  localparam int WEIGHT_FLD_W = 16;
  localparam int RANDOM_W    = 32;
  localparam int ACTIVE_W    = 5;

  // parameter defaults
  localparam int MAX_STATES_DEF  = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // register reset value
  localparam logic [ACTIVE_W-1:0] ACTIVE_RST = 5'd16;

  // command codes
  localparam logic [COMMAND_W-1:0] CMD_LOAD = 1'b0;
  localparam logic [COMMAND_W-1:0] CMD_DRAW = 1'b1;

endpackage

`default_nettype wire

/* design/markov_transition_sampler.sv */
// markov_transition_sampler: roulette-wheel draw over a square weight table
// depends on mts_pkg (field widths, defaults, command codes)
// single module: weight memory, cumulative buffer, sequencer
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports                                              transfer when
// in        input      in_command in_from_state in_to_state in_weight    in_valid & !in_stall
//                      in_random_fraction
// out       output     out_next_state                                     out_valid & !out_stall
// cfg       input      cfg_wr_en cfg_wr_data (active_states)              cfg_wr_en
//
// a load writes the weight at the input transfer edge
// a draw walks the row through the registered-read weight memory, then forms the split
// multiply (low, then high partial product), then binary-searches the registered
// cumulative buffer with a read and a compare per search step
// rst_n is synchronous; it resets the sequencer, clears out_valid and sets active_states to 16
// the weight table is not cleared: entries are undefined until loaded
// in_stall is high whenever a draw is in progress; a finished result sits in the
// output register while further loads are accepted

module markov_transition_sampler #(
  parameter int MAX_STATES  = mts_pkg::MAX_STATES_DEF,
  parameter int WEIGHT_BITS = mts_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mts_pkg::COMMAND_W-1:0]   in_command,
  input  wire logic [mts_pkg::STATE_FLD_W-1:0] in_from_state,
  input  wire logic [mts_pkg::STATE_FLD_W-1:0] in_to_state,
  input  wire logic [mts_pkg::WEIGHT_FLD_W-1:0] in_weight,
  input  wire logic [mts_pkg::RANDOM_W-1:0]    in_random_fraction,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mts_pkg::STATE_FLD_W-1:0]      out_next_state,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [mts_pkg::ACTIVE_W-1:0]    cfg_wr_data
);

  import mts_pkg::*;

  localparam int STATE_W     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int CNT_W       = $clog2(MAX_STATES + 1);
  localparam int TABLE_DEPTH = MAX_STATES * MAX_STATES;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  // row total never exceeds MAX_STATES full-scale weights
  localparam int TOT_W       = WEIGHT_BITS + STATE_W;
  localparam logic [8:0] MAX9 = 9'(MAX_STATES);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WALK   = 7'b0000010,
    ST_MUL_LO = 7'b0000100,
    ST_MUL_HI = 7'b0001000,
    ST_BS_RD  = 7'b0010000,
    ST_BS_CMP = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // storage
  logic [WEIGHT_BITS-1:0] wt_mem [TABLE_DEPTH];
  logic [TOT_W-1:0]       cum_buf [MAX_STATES];

  // control and datapath registers
  state_t                 state_r, state_nxt;
  logic [ACTIVE_W-1:0]    active_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATE_FLD_W-1:0] out_state_r, out_state_nxt;
  logic [STATE_FLD_W-1:0] result_r, result_nxt;
  logic [STATE_W-1:0]     row_r, row_nxt;
  logic [RANDOM_W-1:0]    rnd_r, rnd_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic                   rd_v_r, rd_v_nxt;
  logic [STATE_W-1:0]     rd_col_r, rd_col_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic [63:0]            prod_lo_r, prod_lo_nxt;
  logic [TOT_W-1:0]       thresh_r, thresh_nxt;
  logic [STATE_W-1:0]     lo_r, lo_nxt;
  logic [STATE_W-1:0]     hi_r, hi_nxt;

  // memory read data
  logic [WEIGHT_BITS-1:0] wt_q;
  logic [TOT_W-1:0]       cum_q;

  // combinational helpers
  logic                   in_xfer;
  logic                   out_xfer;
  logic [8:0]             from9;
  logic [8:0]             to9;
  logic [8:0]             act9;
  logic [8:0]             n_eff9;
  logic                   from_ok;
  logic                   to_ok;
  logic [31:0]            wt_ext;
  logic                   wt_we;
  logic [ADDR_W-1:0]      wt_waddr;
  logic [ADDR_W-1:0]      wt_raddr;
  logic [TOT_W-1:0]       run_sum;
  logic                   cum_we;
  logic [STATE_W:0]       mid_sum;
  logic [STATE_W-1:0]     mid;
  logic [63:0]            total_pad;
  logic [63:0]            prod_hi;
  logic [31:0]            idx_ext;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_next_state = out_state_r;

  // range checks against the table size
  assign from9 = {5'b0, in_from_state};
  assign to9   = {5'b0, in_to_state};
  assign from_ok = (from9 < MAX9);
  assign to_ok   = (to9 < MAX9);
  // active count saturated to the table size
  assign act9   = {4'b0, active_r};
  assign n_eff9 = (act9 > MAX9) ? MAX9 : act9;

  // load path: weight trimmed to the stored width
  assign wt_ext   = {16'b0, in_weight};
  assign wt_we    = in_xfer && (in_command == CMD_LOAD) && from_ok && to_ok;
  assign wt_waddr = ADDR_W'(from9[STATE_W-1:0]) * ADDR_W'(MAX_STATES)
                  + ADDR_W'(to9[STATE_W-1:0]);
  // walk address: row base plus running column
  assign wt_raddr = ADDR_W'(row_r) * ADDR_W'(MAX_STATES) + ADDR_W'(col_r[STATE_W-1:0]);

  // the shared accumulator: running total is also the cumulative sum
  assign run_sum = total_r + TOT_W'(wt_q);
  assign cum_we  = (state_r == ST_WALK) && rd_v_r;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[STATE_W:1];

  // r * total split into two partial products over the 32-bit halves of total
  assign total_pad = 64'(total_r);
  assign prod_hi   = rnd_r * total_pad[63:32] + {32'b0, prod_lo_r[63:32]};
  assign idx_ext   = 32'(lo_r);

  // weight memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wt_we) begin
      wt_mem[wt_waddr] <= wt_ext[WEIGHT_BITS-1:0];
    end
    wt_q <= wt_mem[wt_raddr];
  end

  // cumulative buffer for the binary search
  always_ff @(posedge clk) begin
    if (cum_we) begin
      cum_buf[rd_col_r] <= run_sum;
    end
    cum_q <= cum_buf[mid];
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_state_nxt = out_state_r;
    result_nxt    = result_r;
    row_nxt       = row_r;
    rnd_nxt       = rnd_r;
    n_nxt         = n_r;
    col_nxt       = col_r;
    rd_v_nxt      = rd_v_r;
    rd_col_nxt    = rd_col_r;
    total_nxt     = total_r;
    prod_lo_nxt   = prod_lo_r;
    thresh_nxt    = thresh_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_command == CMD_DRAW)) begin
          result_nxt = in_from_state;
          rnd_nxt    = in_random_fraction;
          row_nxt    = from9[STATE_W-1:0];
          n_nxt      = CNT_W'(n_eff9);
          col_nxt    = '0;
          rd_v_nxt   = 1'b0;
          total_nxt  = '0;
          // out-of-range state or no active columns: stay put
          if (!from_ok || (n_eff9 == 9'd0)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (rd_v_r) begin
          total_nxt = run_sum;
        end
        if (col_r < n_r) begin
          rd_v_nxt   = 1'b1;
          rd_col_nxt = col_r[STATE_W-1:0];
          col_nxt    = col_r + 1'b1;
        end else begin
          rd_v_nxt = 1'b0;
          if (!rd_v_r) begin
            if (total_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_MUL_LO;
            end
          end
        end
      end
      ST_MUL_LO: begin
        prod_lo_nxt = rnd_r * total_pad[31:0];
        state_nxt   = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        // floor(r * total / 2^32) always stays below total
        thresh_nxt = prod_hi[TOT_W-1:0];
        lo_nxt     = '0;
        hi_nxt     = STATE_W'(n_r - 1'b1);
        state_nxt  = ST_BS_RD;
      end
      ST_BS_RD: begin
        if (lo_r == hi_r) begin
          result_nxt = idx_ext[STATE_FLD_W-1:0];
          state_nxt  = ST_DONE;
        end else begin
          state_nxt = ST_BS_CMP;
        end
      end
      ST_BS_CMP: begin
        // first column whose cumulative sum exceeds the threshold
        if (cum_q > thresh_r) begin
          hi_nxt = mid;
        end else begin
          lo_nxt = mid + 1'b1;
        end
        state_nxt = ST_BS_RD;
      end
      ST_DONE: begin
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          out_state_nxt = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      active_r    <= ACTIVE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        active_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_state_r <= out_state_nxt;
    result_r    <= result_nxt;
    row_r       <= row_nxt;
    rnd_r       <= rnd_nxt;
    n_r         <= n_nxt;
    col_r       <= col_nxt;
    rd_v_r      <= rd_v_nxt;
    rd_col_r    <= rd_col_nxt;
    total_r     <= total_nxt;
    prod_lo_r   <= prod_lo_nxt;
    thresh_r    <= thresh_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
  end

endmodule

`default_nettype wire
